@@ hw/rtl/ille_pkg.sv @@
`default_nettype none
package ille_pkg;

  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = SLOT_W + 1;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 12;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;

  localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - POS_W - DATA_W;
  localparam int OUT_TDATA_W = ((DATA_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - LEN_W;

  localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(CAPACITY);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_HEAD   = 3'd1,
    KIND_TAIL   = 3'd2,
    KIND_AT     = 3'd3,
    KIND_DELETE = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_IGNORE = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_RD_WAIT,
    ST_ALLOC,
    ST_ALLOC_WAIT,
    ST_PLACE,
    ST_INS_WAIT,
    ST_INS_LINK,
    ST_DEL_HEAD,
    ST_DEL_VICTIM,
    ST_DEL_UNLINK,
    ST_DEL_FREE,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/indexed_linked_list_engine_core.sv @@
// Indexed linked-list engine: holds an ordered list of up to CAPACITY signed
// 32-bit values as nodes in two one-port-read/one-port-write memories (values
// and next-links) with a free-slot list fed by deletes. Each input beat is one
// request (read, insert at head, append, insert before a position, delete at a
// position) and yields exactly one output beat with the read value (-1 unless
// a read succeeds), a status and the new list length. Requests are handled one
// at a time; positions are found by walking the link memory from the head,
// one link read per cycle. The result sits in an output register, so the
// next request is accepted as soon as the result has moved there, even
// while the previous result still waits for out_tready. The memories
// need no clearing pass after reset: every slot is written when allocated.
`default_nettype none
module indexed_linked_list_engine_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // request channel
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // in_tdata, low bit up: position[11:0], item_value[31:0], zero pad
  input  wire  [ille_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: kind[2:0]
  input  wire  [ille_pkg::KIND_W-1:0]         in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // out_tdata, low bit up: read_value[31:0], list_length[10:0], zero pad
  output logic [ille_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: status[1:0]
  output logic [ille_pkg::STATUS_W-1:0]       out_tuser
);

  localparam int SLOT_W = ille_pkg::SLOT_W;
  localparam int LINK_W = ille_pkg::LINK_W;
  localparam int POS_W  = ille_pkg::POS_W;
  localparam int DATA_W = ille_pkg::DATA_W;
  localparam int LEN_W  = ille_pkg::LEN_W;

  // node storage
  logic [DATA_W-1:0] value_mem [ille_pkg::CAPACITY];
  logic [LINK_W-1:0] link_mem  [ille_pkg::CAPACITY];

  logic              val_we, val_re;
  logic [SLOT_W-1:0] val_raddr;
  logic [DATA_W-1:0] val_rdata;
  logic              link_we, link_re;
  logic [SLOT_W-1:0] link_waddr, link_raddr;
  logic [LINK_W-1:0] link_wdata, link_rdata;

  // sequencer and list state
  ille_pkg::state_t  state_r, state_nxt;
  ille_pkg::kind_t   kind_r, kind_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0] free_r, free_nxt;
  logic [LINK_W-1:0] fresh_r, fresh_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  ille_pkg::status_t status_r, status_nxt;

  // output register
  logic                    out_valid_r;
  logic                    out_load;
  logic [DATA_W-1:0]       out_rd_r;
  logic [LEN_W-1:0]        out_len_r;
  ille_pkg::status_t       out_status_r;

  logic                    accept;
  ille_pkg::kind_t         in_kind;
  logic [POS_W-1:0]        in_pos;
  logic [DATA_W-1:0]       in_val;
  logic [POS_W-1:0]        len_ext;
  logic [POS_W-1:0]        ins_pos;
  logic [LINK_W-1:0]       cur_w;

  assign in_kind   = ille_pkg::kind_t'(in_tuser);
  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_val    = in_tdata[POS_W+DATA_W-1:POS_W];
  assign len_ext   = POS_W'(count_r);
  assign in_tready = (state_r == ille_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // insert position: head is 0, append is the current length
  always_comb begin
    if (in_kind == ille_pkg::KIND_HEAD) begin
      ins_pos = '0;
    end else if (in_kind == ille_pkg::KIND_TAIL) begin
      ins_pos = len_ext;
    end else begin
      ins_pos = in_pos;
    end
  end

  // while walking, the link just read is the next node to visit
  assign cur_w = pend_r ? link_rdata : cur_r;

  // Memories: one read and one write per cycle each. The sequencer never
  // reads an entry in the cycle it writes it, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[slot_r] <= val_r;
    end
    if (val_re) begin
      val_rdata <= value_mem[val_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ille_pkg::ST_IDLE;
      pend_r  <= 1'b0;
      head_r  <= ille_pkg::NULL_SLOT;
      count_r <= '0;
      free_r  <= ille_pkg::NULL_SLOT;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    cnt_r    <= cnt_nxt;
    cur_r    <= cur_nxt;
    slot_r   <= slot_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    slot_nxt   = slot_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    free_nxt   = free_r;
    fresh_nxt  = fresh_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    val_we     = 1'b0;
    val_re     = 1'b0;
    val_raddr  = cur_w[SLOT_W-1:0];
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_waddr = slot_r;
    link_wdata = free_r;
    link_raddr = cur_w[SLOT_W-1:0];
    out_load   = 1'b0;

    unique case (state_r)
      ille_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          val_nxt    = in_val;
          rd_nxt     = '1;
          status_nxt = ille_pkg::STAT_DONE;
          cur_nxt    = head_r;
          pend_nxt   = 1'b0;
          unique case (in_kind) inside
            ille_pkg::KIND_READ: begin
              if (in_pos >= len_ext) begin
                status_nxt = ille_pkg::STAT_IGNORE;
                state_nxt  = ille_pkg::ST_RESP;
              end else begin
                cnt_nxt   = in_pos[SLOT_W-1:0];
                state_nxt = ille_pkg::ST_WALK;
              end
            end
            ille_pkg::KIND_HEAD, ille_pkg::KIND_TAIL, ille_pkg::KIND_AT: begin
              // range check comes before the full check
              if (in_kind == ille_pkg::KIND_AT && in_pos > len_ext) begin
                status_nxt = ille_pkg::STAT_IGNORE;
                state_nxt  = ille_pkg::ST_RESP;
              end else if (count_r >= LEN_W'(ille_pkg::CAPACITY)) begin
                status_nxt = ille_pkg::STAT_FULL;
                state_nxt  = ille_pkg::ST_RESP;
              end else begin
                pos_nxt   = ins_pos[SLOT_W-1:0];
                state_nxt = ille_pkg::ST_ALLOC;
              end
            end
            ille_pkg::KIND_DELETE: begin
              if (in_pos >= len_ext) begin
                status_nxt = ille_pkg::STAT_IGNORE;
                state_nxt  = ille_pkg::ST_RESP;
              end else if (in_pos == '0) begin
                link_re    = 1'b1;
                link_raddr = head_r[SLOT_W-1:0];
                state_nxt  = ille_pkg::ST_DEL_HEAD;
              end else begin
                cnt_nxt   = SLOT_W'(in_pos - POS_W'(1));
                state_nxt = ille_pkg::ST_WALK;
              end
            end
            default: begin
              status_nxt = ille_pkg::STAT_IGNORE;
              state_nxt  = ille_pkg::ST_RESP;
            end
          endcase
        end
      end

      // follow one link per cycle until the target node is reached
      ille_pkg::ST_WALK: begin
        cur_nxt = cur_w;
        if (cnt_r == '0) begin
          pend_nxt = 1'b0;
          case (kind_r) inside
            ille_pkg::KIND_READ: begin
              val_re    = 1'b1;
              state_nxt = ille_pkg::ST_RD_WAIT;
            end
            ille_pkg::KIND_DELETE: begin
              link_re   = 1'b1;
              state_nxt = ille_pkg::ST_DEL_VICTIM;
            end
            default: begin
              link_re   = 1'b1;
              state_nxt = ille_pkg::ST_INS_WAIT;
            end
          endcase
        end else begin
          link_re  = 1'b1;
          cnt_nxt  = cnt_r - SLOT_W'(1);
          pend_nxt = 1'b1;
        end
      end

      ille_pkg::ST_RD_WAIT: begin
        rd_nxt    = val_rdata;
        state_nxt = ille_pkg::ST_RESP;
      end

      // take a slot from the free list, else the next never-used one
      ille_pkg::ST_ALLOC: begin
        if (free_r < ille_pkg::NULL_SLOT) begin
          link_re    = 1'b1;
          link_raddr = free_r[SLOT_W-1:0];
          slot_nxt   = free_r[SLOT_W-1:0];
          state_nxt  = ille_pkg::ST_ALLOC_WAIT;
        end else begin
          slot_nxt  = (fresh_r < ille_pkg::NULL_SLOT) ? fresh_r[SLOT_W-1:0] : '0;
          fresh_nxt = fresh_r + LINK_W'(1);
          state_nxt = ille_pkg::ST_PLACE;
        end
      end

      ille_pkg::ST_ALLOC_WAIT: begin
        free_nxt  = link_rdata;
        state_nxt = ille_pkg::ST_PLACE;
      end

      ille_pkg::ST_PLACE: begin
        val_we = 1'b1;
        if (pos_r == '0) begin
          link_we    = 1'b1;
          link_wdata = head_r;
          head_nxt   = LINK_W'(slot_r);
          count_nxt  = count_r + LEN_W'(1);
          state_nxt  = ille_pkg::ST_RESP;
        end else begin
          cnt_nxt   = pos_r - SLOT_W'(1);
          cur_nxt   = head_r;
          pend_nxt  = 1'b0;
          state_nxt = ille_pkg::ST_WALK;
        end
      end

      // new node takes over the predecessor's link
      ille_pkg::ST_INS_WAIT: begin
        link_we    = 1'b1;
        link_wdata = link_rdata;
        state_nxt  = ille_pkg::ST_INS_LINK;
      end

      ille_pkg::ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r[SLOT_W-1:0];
        link_wdata = LINK_W'(slot_r);
        count_nxt  = count_r + LEN_W'(1);
        state_nxt  = ille_pkg::ST_RESP;
      end

      ille_pkg::ST_DEL_HEAD: begin
        head_nxt   = link_rdata;
        link_we    = 1'b1;
        link_waddr = head_r[SLOT_W-1:0];
        link_wdata = free_r;
        free_nxt   = head_r;
        count_nxt  = count_r - LEN_W'(1);
        state_nxt  = ille_pkg::ST_RESP;
      end

      ille_pkg::ST_DEL_VICTIM: begin
        slot_nxt   = link_rdata[SLOT_W-1:0];
        link_re    = 1'b1;
        link_raddr = link_rdata[SLOT_W-1:0];
        state_nxt  = ille_pkg::ST_DEL_UNLINK;
      end

      // bridge the predecessor over the victim
      ille_pkg::ST_DEL_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r[SLOT_W-1:0];
        link_wdata = link_rdata;
        state_nxt  = ille_pkg::ST_DEL_FREE;
      end

      // push the victim onto the free list
      ille_pkg::ST_DEL_FREE: begin
        link_we    = 1'b1;
        link_wdata = free_r;
        free_nxt   = LINK_W'(slot_r);
        count_nxt  = count_r - LEN_W'(1);
        state_nxt  = ille_pkg::ST_RESP;
      end

      // hold the result until the output register is free
      ille_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ille_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ille_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r     <= rd_r;
      out_len_r    <= count_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{ille_pkg::OUT_PAD_W{1'b0}}, out_len_r, out_rd_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

@@ hw/rtl/ille_checker.sv @@
`default_nettype none
module ille_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [ille_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire [ille_pkg::KIND_W-1:0]       in_tuser,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [ille_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire [ille_pkg::STATUS_W-1:0]     out_tuser
);

  localparam int DATA_W = ille_pkg::DATA_W;
  localparam int LEN_W  = ille_pkg::LEN_W;

  logic [DATA_W-1:0] rd_value;
  logic [LEN_W-1:0]  len_value;
  logic              req_bits_seen;

  assign rd_value      = out_tdata[DATA_W-1:0];
  assign len_value     = out_tdata[DATA_W+LEN_W-1:DATA_W];
  assign req_bits_seen = ^{in_tdata, in_tuser} || 1'b1;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one request in flight: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && req_bits_seen |=> !in_tready)
    else $error("request accepted while previous one in flight");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ille_pkg::STAT_FULL |->
      len_value == LEN_W'(ille_pkg::CAPACITY))
    else $error("full status with list not at capacity");

  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ille_pkg::STAT_DONE |-> rd_value == '1)
    else $error("failed request returned a value other than -1");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind indexed_linked_list_engine_core ille_checker u_ille_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ tb/sv/indexed_linked_list_engine_core_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module indexed_linked_list_engine_core_tb;

  localparam int KIND_W      = ille_pkg::KIND_W;
  localparam int POS_W       = ille_pkg::POS_W;
  localparam int DATA_W      = ille_pkg::DATA_W;
  localparam int LEN_W       = ille_pkg::LEN_W;
  localparam int STATUS_W    = ille_pkg::STATUS_W;
  localparam int CAPACITY    = ille_pkg::CAPACITY;
  localparam int IN_TDATA_W  = ille_pkg::IN_TDATA_W;
  localparam int IN_PAD_W    = ille_pkg::IN_PAD_W;
  localparam int OUT_TDATA_W = ille_pkg::OUT_TDATA_W;

  localparam int KIND_MAX    = (1 << KIND_W) - 1;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int MAX_IDLE    = 12;
  localparam int RANDOM_REQS = 580;
  // longest walk plus margin; used for the quiet window at the end
  localparam int WALK_CYCLES = CAPACITY + 80;

  // one request waiting to be sent
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                drain_first;  // hold until every result is back
  } request_t;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    ille_pkg::status_t status;
    logic [LEN_W-1:0]  list_length;
  } result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  request_t          pending_requests[$];
  result_t           expected_results[$];
  logic [DATA_W-1:0] list_entries[$];   // predicted list, head first
  int                plan_len;          // list length as seen while generating
  int unsigned       error_count;

  // sender state
  int       send_gap;
  bit       send_burst;
  bit       offer;
  request_t next_req;

  // receiver state
  int      recv_gap;
  bit      recv_burst;
  bit      take;
  result_t want;

  indexed_linked_list_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predicted list and return the result beat it
  // should produce. Positions count from the head.
  function automatic result_t predict_request(logic [KIND_W-1:0] kind,
                                              logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
    result_t r;
    int      len;
    len           = list_entries.size();
    r.read_value  = '1;
    r.status      = ille_pkg::STAT_DONE;
    case (kind)
      ille_pkg::KIND_READ: begin
        if (pos >= len) r.status = ille_pkg::STAT_IGNORE;
        else r.read_value = list_entries[pos];
      end
      ille_pkg::KIND_HEAD: begin
        if (len >= CAPACITY) r.status = ille_pkg::STAT_FULL;
        else list_entries.push_front(val);
      end
      ille_pkg::KIND_TAIL: begin
        if (len >= CAPACITY) r.status = ille_pkg::STAT_FULL;
        else list_entries.push_back(val);
      end
      ille_pkg::KIND_AT: begin
        // range check wins over the full check
        if (pos > len) r.status = ille_pkg::STAT_IGNORE;
        else if (len >= CAPACITY) r.status = ille_pkg::STAT_FULL;
        else list_entries.insert(pos, val);
      end
      ille_pkg::KIND_DELETE: begin
        if (pos >= len) r.status = ille_pkg::STAT_IGNORE;
        else list_entries.delete(pos);
      end
      default: r.status = ille_pkg::STAT_IGNORE;
    endcase
    r.list_length = LEN_W'(list_entries.size());
    return r;
  endfunction

  // Queue one request and track the list length it leaves behind, so the
  // generator can aim positions at the live list.
  task automatic queue_request(logic [KIND_W-1:0] kind, int pos, logic [DATA_W-1:0] val,
                               bit drain_first = 1'b0);
    request_t req;
    req.kind        = kind;
    req.pos         = POS_W'(pos);
    req.val         = val;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
    case (kind)
      ille_pkg::KIND_HEAD, ille_pkg::KIND_TAIL: if (plan_len < CAPACITY) plan_len++;
      ille_pkg::KIND_AT:     if (req.pos <= plan_len && plan_len < CAPACITY) plan_len++;
      ille_pkg::KIND_DELETE: if (req.pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  // Mostly random words, now and then one of the extremes.
  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pick a position: mostly inside the list or one past its end, sometimes
  // anywhere in the 12-bit range.
  function automatic int draw_pos();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, POS_MAX);
    return $urandom_range(0, plan_len);
  endfunction

  // Draw how long one side idles before its next beat. Burst mode gives long
  // stretches with no idling at all.
  function automatic int draw_idle(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Sender: present the next queued request, hold it until accepted, then
  // idle for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      send_gap   = 0;
      send_burst = 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(
          predict_request(in_tuser, in_tdata[POS_W-1:0], in_tdata[POS_W +: DATA_W]));
        offer    = 1'b0;
        send_gap = draw_idle(send_burst);
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].drain_first || expected_results.size() == 0)) begin
          next_req = pending_requests.pop_front();
          in_tuser <= next_req.kind;
          in_tdata <= {{IN_PAD_W{1'b0}}, next_req.val, next_req.pos};
          offer    = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // Receiver: check each result beat against the oldest prediction, then
  // drop out_tready for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   = 0;
      recv_burst = 1'b0;
    end else begin
      take = out_tready;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(want.read_value), $signed(out_tdata[DATA_W-1:0]));
            error_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            error_count++;
          end
          if (out_tdata[DATA_W +: LEN_W] !== want.list_length) begin
            $error("list_length: expected %0d, got %0d",
                   want.list_length, out_tdata[DATA_W +: LEN_W]);
            error_count++;
          end
        end
        recv_gap = draw_idle(recv_burst);
        take     = (recv_gap == 0);
        if (recv_gap != 0) recv_gap--;
      end else if (!out_tready) begin
        if (recv_gap == 0) take = 1'b1;
        else recv_gap--;
      end
      out_tready <= take;
    end
  end

  // Stimulus and end of run.
  initial begin
    int roll;
    int grow;
    error_count = 0;
    plan_len    = 0;

    // Directed: empty list, the extremes and every range edge.
    queue_request(ille_pkg::KIND_READ, 0, draw_value());
    queue_request(ille_pkg::KIND_DELETE, 0, draw_value());
    queue_request(ille_pkg::KIND_AT, 1, draw_value());                  // past the end
    queue_request(ille_pkg::KIND_TAIL, 0, {1'b0, {(DATA_W-1){1'b1}}});  // append to empty
    queue_request(ille_pkg::KIND_READ, 0, '0);
    queue_request(ille_pkg::KIND_HEAD, 0, {1'b1, {(DATA_W-1){1'b0}}});
    queue_request(ille_pkg::KIND_AT, 2, '1);                            // at length: append
    queue_request(ille_pkg::KIND_AT, 1, '0);
    for (int p = 0; p <= 4; p++) queue_request(ille_pkg::KIND_READ, p, draw_value());
    queue_request(ille_pkg::KIND_READ, POS_MAX, '1);
    for (int k = ille_pkg::KIND_DELETE + 1; k <= KIND_MAX; k++)
      queue_request(KIND_W'(k), $urandom_range(0, POS_MAX), $urandom);
    queue_request(ille_pkg::KIND_DELETE, 3, draw_value());              // tail
    queue_request(ille_pkg::KIND_DELETE, 1, draw_value());              // middle
    queue_request(ille_pkg::KIND_DELETE, POS_MAX, draw_value());
    queue_request(ille_pkg::KIND_DELETE, 0, draw_value(), 1'b1);        // head, after a drain
    queue_request(ille_pkg::KIND_HEAD, 0, 32'h5555_AAAA);               // reuses a freed slot
    queue_request(ille_pkg::KIND_READ, 0, draw_value());
    queue_request(ille_pkg::KIND_READ, 1, draw_value());

    // Random mix on a short list, drifting between empty and a few dozen.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      grow = plan_len < 8 ? 70 : (plan_len > 40 ? 25 : 45);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        queue_request(KIND_W'($urandom_range(ille_pkg::KIND_DELETE + 1, KIND_MAX)),
                      draw_pos(), $urandom);
      end else if (roll < 5 + grow) begin
        case ($urandom_range(0, 2))
          0:       queue_request(ille_pkg::KIND_HEAD, draw_pos(), draw_value(),
                                 i % 97 == 96);
          1:       queue_request(ille_pkg::KIND_TAIL, draw_pos(), draw_value());
          default: queue_request(ille_pkg::KIND_AT, draw_pos(), draw_value());
        endcase
      end else if ($urandom_range(0, 99) < 45) begin
        queue_request(ille_pkg::KIND_READ, draw_pos(), $urandom);
      end else begin
        queue_request(ille_pkg::KIND_DELETE, draw_pos(), $urandom);
      end
    end

    // Fill the store with cheap inserts near the head, reading now and then.
    queue_request(ille_pkg::KIND_HEAD, 0, draw_value(), 1'b1);
    while (plan_len < CAPACITY) begin
      roll = $urandom_range(0, 39);
      if (roll == 0)
        queue_request(ille_pkg::KIND_READ, $urandom_range(0, plan_len - 1), $urandom);
      else if (roll < 20)
        queue_request(ille_pkg::KIND_HEAD, 0, draw_value());
      else
        queue_request(ille_pkg::KIND_AT, $urandom_range(0, plan_len < 3 ? plan_len : 3),
                      draw_value());
    end

    // Full store: inserts refused while full, range checks still first; deletes then make room.
    queue_request(ille_pkg::KIND_HEAD, 0, draw_value());
    queue_request(ille_pkg::KIND_TAIL, 0, draw_value());
    queue_request(ille_pkg::KIND_AT, 0, draw_value());
    queue_request(ille_pkg::KIND_AT, CAPACITY, draw_value());
    queue_request(ille_pkg::KIND_AT, CAPACITY + 1, draw_value());
    queue_request(ille_pkg::KIND_AT, POS_MAX, draw_value());
    queue_request(ille_pkg::KIND_READ, CAPACITY - 1, draw_value());
    queue_request(ille_pkg::KIND_READ, CAPACITY, draw_value());
    queue_request(ille_pkg::KIND_DELETE, CAPACITY, draw_value());
    queue_request(ille_pkg::KIND_DELETE, CAPACITY - 1, draw_value());
    queue_request(ille_pkg::KIND_TAIL, 0, draw_value());
    queue_request(ille_pkg::KIND_READ, CAPACITY - 1, draw_value());
    queue_request(ille_pkg::KIND_DELETE, CAPACITY / 2, draw_value());
    queue_request(ille_pkg::KIND_AT, CAPACITY / 2, draw_value());
    queue_request(ille_pkg::KIND_READ, CAPACITY / 2, draw_value());
    for (int i = 0; i < 24; i++) begin
      case ($urandom_range(0, 4))
        0:       queue_request(ille_pkg::KIND_READ, $urandom_range(0, plan_len), $urandom);
        1:       queue_request(ille_pkg::KIND_DELETE, $urandom_range(0, plan_len), $urandom);
        2:       queue_request(ille_pkg::KIND_HEAD, 0, draw_value());
        3:       queue_request(ille_pkg::KIND_TAIL, 0, draw_value());
        default: queue_request(ille_pkg::KIND_AT, $urandom_range(0, plan_len + 1),
                               draw_value());
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // give a stray extra beat time to show up
    repeat (WALK_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run of this stimulus.
  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
